### hdl/mtc_pkg.sv
// Shared types and constants for the magnetometer trim compensation unit.
package mtc_pkg;

	// Width of the quotient produced by each divider; larger quotients are flagged.
	localparam int QUO_W = 25;

	// Configuration register indexes (byte address / 8).
	localparam logic [2:0] REG_XY_TRIM = 3'd0;
	localparam logic [2:0] REG_Z1_TRIM = 3'd1;
	localparam logic [2:0] REG_Z2_TRIM = 3'd2;
	localparam logic [2:0] REG_Z3_TRIM = 3'd3;
	localparam logic [2:0] REG_Z4_TRIM = 3'd4;
	localparam logic [2:0] REG_XYZ1_TRIM = 3'd5;

	// Overflow sentinels of the raw axis data.
	localparam logic signed [12:0] XY_OVF_CODE = 13'sh1000;
	localparam logic signed [14:0] Z_OVF_CODE = 15'sh4000;

	// Saturation limits.
	localparam logic signed [24:0] D_MAX = 25'sh0FFFFFF;
	localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] OUT_MIN = 24'sh800000;

	// One burst read of eight data bytes.
	typedef struct packed {
		logic [7:0] x_low_byte;
		logic [7:0] x_high_byte;
		logic [7:0] y_low_byte;
		logic [7:0] y_high_byte;
		logic [7:0] z_low_byte;
		logic [7:0] z_high_byte;
		logic [7:0] hall_low_byte;
		logic [7:0] hall_high_byte;
	} in_item_t;

	// One compensated result.
	typedef struct packed {
		logic signed [23:0] field_x;
		logic signed [23:0] field_y;
		logic signed [23:0] field_z;
		logic [2:0] axis_invalid;
	} out_item_t;

	// Side data that rides along the X/Y resistance divider.
	typedef struct packed {
		logic signed [21:0] kx;
		logic signed [21:0] ky;
		logic inv_x;
		logic inv_y;
	} xy_tag_t;

	// Side data that rides along the Z divider.
	typedef struct packed {
		logic neg;
		logic inv_z;
	} z_tag_t;

endpackage

### hdl/mtc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with overflow flag.
module mtc_div #(
	parameter int NW = 29,
	parameter int DW = 14,
	parameter int QW = 25,
	parameter int TW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic [TW-1:0] tag_out
);

	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic          vld_s [0:QW];
	logic [NW-1:0] rem_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic          ovf_s [0:QW];
	logic [TW-1:0] tag_s [0:QW];

	// Entry stage: load operands and flag quotients that do not fit in QW bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= CW'(num) >= (CW'(den) << QW);
		tag_s[0] <= tag_in;
	end

	// One trial subtraction per stage, most significant quotient bit first.
	for (genvar g = 0; g < QW; g++) begin : g_step
		localparam int B = QW - 1 - g;
		logic [CW-1:0] trial;
		logic          take;

		assign trial = CW'(den_s[g]) << B;
		assign take = CW'(rem_s[g]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= take ? NW'(CW'(rem_s[g]) - trial) : rem_s[g];
			quo_s[g+1] <= {quo_s[g][QW-2:0], take};
			den_s[g+1] <= den_s[g];
			ovf_s[g+1] <= ovf_s[g];
			tag_s[g+1] <= tag_s[g];
		end
	end

	assign out_valid = vld_s[QW];
	assign quo = quo_s[QW];
	assign ovf = ovf_s[QW];
	assign tag_out = tag_s[QW];

endmodule

### hdl/magnetometer_trim_compensation_unit.sv
// Top level of the magnetometer trim compensation unit: registers, pipeline and output.
//
//  channel   handshake                    payload
//  ------    ---------------------------  -----------------------------
//  config    psel/penable/pwrite/pready   paddr, pwdata, prdata
//  input     start, busy                  in_item (eight data bytes)
//  result    done                         out_item (x, y, z, invalid bits)
//
// One beat enters every cycle; busy is never raised. A beat with the
// data-ready bit set gives one result; the pipeline depth is set
// by the two 26-stage pipelined dividers plus the multiply stages.
// Reset clears the trim registers and all pipeline valid bits.
// The result strobe lasts one cycle and the receiver cannot stall it.
module magnetometer_trim_compensation_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  mtc_pkg::in_item_t  in_item,
	output logic               done,
	output mtc_pkg::out_item_t out_item
);

	localparam int LAT = 4 + (mtc_pkg::QUO_W + 1) + 7;
	localparam int XTW = $bits(mtc_pkg::xy_tag_t);
	localparam int ZTW = $bits(mtc_pkg::z_tag_t);

	// Trim registers.
	logic [47:0]        xy_trim_q;
	logic [15:0]        z1_q;
	logic signed [15:0] z2_q;
	logic signed [15:0] z3_q;
	logic signed [15:0] z4_q;
	logic [14:0]        xyz1_q;

	logic signed [7:0] x1, y1, x2, y2, xy2;
	logic [7:0]        xy1;

	assign x1 = xy_trim_q[7:0];
	assign y1 = xy_trim_q[15:8];
	assign x2 = xy_trim_q[23:16];
	assign y2 = xy_trim_q[31:24];
	assign xy1 = xy_trim_q[39:32];
	assign xy2 = xy_trim_q[47:40];

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xy_trim_q <= '0;
			z1_q <= '0;
			z2_q <= '0;
			z3_q <= '0;
			z4_q <= '0;
			xyz1_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[5:3])
				mtc_pkg::REG_XY_TRIM:   xy_trim_q <= pwdata[47:0];
				mtc_pkg::REG_Z1_TRIM:   z1_q <= pwdata[15:0];
				mtc_pkg::REG_Z2_TRIM:   z2_q <= pwdata[15:0];
				mtc_pkg::REG_Z3_TRIM:   z3_q <= pwdata[15:0];
				mtc_pkg::REG_Z4_TRIM:   z4_q <= pwdata[15:0];
				mtc_pkg::REG_XYZ1_TRIM: xyz1_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// Register read mux.
	always_comb begin
		unique case (paddr[5:3])
			mtc_pkg::REG_XY_TRIM:   prdata = {16'd0, xy_trim_q};
			mtc_pkg::REG_Z1_TRIM:   prdata = {48'd0, z1_q};
			mtc_pkg::REG_Z2_TRIM:   prdata = {48'd0, z2_q};
			mtc_pkg::REG_Z3_TRIM:   prdata = {48'd0, z3_q};
			mtc_pkg::REG_Z4_TRIM:   prdata = {48'd0, z4_q};
			mtc_pkg::REG_XYZ1_TRIM: prdata = {49'd0, xyz1_q};
			default:                prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign busy = 1'b0;

	// Stage 1: unpack the burst bytes.
	logic               vld_s1;
	logic signed [12:0] rx_s1, ry_s1;
	logic signed [14:0] rz_s1;
	logic [13:0]        rh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy && in_item.hall_low_byte[0];
		end
	end

	always_ff @(posedge clk) begin
		rx_s1 <= {in_item.x_high_byte, in_item.x_low_byte[7:3]};
		ry_s1 <= {in_item.y_high_byte, in_item.y_low_byte[7:3]};
		rz_s1 <= {in_item.z_high_byte, in_item.z_low_byte[7:1]};
		rh_s1 <= {in_item.hall_high_byte, in_item.hall_low_byte[7:2]};
	end

	// Stage 2: sensitivity products, Z partial products and invalid flags.
	logic signed [9:0]  sx, sy;
	logic signed [16:0] hd;
	logic               vld_s2;
	logic signed [21:0] kx_s2, ky_s2;
	logic signed [16:0] zd_s2;
	logic signed [32:0] z3h_s2;
	logic [29:0]        z1rh_s2;
	logic [13:0]        rh_s2;
	logic               invx_s2, invy_s2, invz_s2;

	assign sx = 10'(x2) + 10'sd160;
	assign sy = 10'(y2) + 10'sd160;
	assign hd = $signed({3'b000, rh_s1}) - $signed({2'b00, xyz1_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		kx_s2 <= 22'(rx_s1) * 22'(sx);
		ky_s2 <= 22'(ry_s1) * 22'(sy);
		zd_s2 <= 17'(rz_s1) - 17'(z4_q);
		z3h_s2 <= 33'(z3_q) * 33'(hd);
		z1rh_s2 <= 30'(z1_q) * 30'(rh_s1);
		rh_s2 <= rh_s1;
		invx_s2 <= (rx_s1 == mtc_pkg::XY_OVF_CODE) || (rh_s1 == '0) || (xyz1_q == '0);
		invy_s2 <= (ry_s1 == mtc_pkg::XY_OVF_CODE) || (rh_s1 == '0) || (xyz1_q == '0);
		invz_s2 <= (rz_s1 == mtc_pkg::Z_OVF_CODE) || (rh_s1 == '0) || (z1_q == '0)
			|| (z2_q == '0);
	end

	// Stage 3: Z numerator and denominator.
	logic               vld_s3;
	logic signed [34:0] num_s3;
	logic signed [31:0] den_s3;
	logic signed [21:0] kx_s3, ky_s3;
	logic [13:0]        rh_s3;
	logic               invx_s3, invy_s3, invz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		num_s3 <= (35'(zd_s2) <<< 17) - 35'(z3h_s2);
		den_s3 <= (32'(z2_q) <<< 15) + $signed({2'b00, z1rh_s2});
		kx_s3 <= kx_s2;
		ky_s3 <= ky_s2;
		rh_s3 <= rh_s2;
		invx_s3 <= invx_s2;
		invy_s3 <= invy_s2;
		invz_s3 <= invz_s2;
	end

	// Stage 4: magnitudes and quotient sign for the Z division.
	logic               vld_s4;
	logic [47:0]        nmag_s4;
	logic [31:0]        dmag_s4;
	logic [13:0]        rh_s4;
	mtc_pkg::xy_tag_t   xtag_s4;
	mtc_pkg::z_tag_t    ztag_s4;
	logic signed [34:0] nabs;
	logic signed [31:0] dabs;

	assign nabs = num_s3[34] ? -num_s3 : num_s3;
	assign dabs = den_s3[31] ? -den_s3 : den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		nmag_s4 <= 48'(nabs) << 13;
		dmag_s4 <= dabs;
		rh_s4 <= rh_s3;
		xtag_s4 <= '{kx: kx_s3, ky: ky_s3, inv_x: invx_s3, inv_y: invy_s3};
		ztag_s4 <= '{neg: num_s3[34] ^ den_s3[31], inv_z: invz_s3 || (den_s3 == '0)};
	end

	// Dividers: resistance ratio for X/Y and the Z quotient.
	logic                       xv_p0, zv_p0, xovf_p0, zovf_p0;
	logic [mtc_pkg::QUO_W-1:0]  xq_p0, zq_p0;
	logic [XTW-1:0]             xtag_raw;
	logic [ZTW-1:0]             ztag_raw;
	mtc_pkg::xy_tag_t           xtag_p0;
	mtc_pkg::z_tag_t            ztag_p0;

	mtc_div #(.NW(29), .DW(14), .QW(mtc_pkg::QUO_W), .TW(XTW)) u_xy_div (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s4),
		.num({xyz1_q, 14'd0}), .den(rh_s4), .tag_in(xtag_s4),
		.out_valid(xv_p0), .quo(xq_p0), .ovf(xovf_p0), .tag_out(xtag_raw)
	);

	mtc_div #(.NW(48), .DW(32), .QW(mtc_pkg::QUO_W), .TW(ZTW)) u_z_div (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s4),
		.num(nmag_s4), .den(dmag_s4), .tag_in(ztag_s4),
		.out_valid(zv_p0), .quo(zq_p0), .ovf(zovf_p0), .tag_out(ztag_raw)
	);

	assign xtag_p0 = xtag_raw;
	assign ztag_p0 = ztag_raw;

	// Post stage 1: saturated ratio offset d and the finished Z value.
	logic signed [25:0] dt;
	logic signed [23:0] fz_c;
	logic               vld_p1;
	logic signed [24:0] d_p1;
	logic signed [23:0] fz_p1;
	mtc_pkg::xy_tag_t   xtag_p1;
	logic               invz_p1;

	assign dt = $signed({1'b0, xq_p0}) - 26'sd16384;

	always_comb begin
		if (ztag_p0.inv_z) begin
			fz_c = '0;
		end else if (zovf_p0) begin
			fz_c = ztag_p0.neg ? mtc_pkg::OUT_MIN : mtc_pkg::OUT_MAX;
		end else if (ztag_p0.neg) begin
			fz_c = (zq_p0 > 25'd8388608) ? mtc_pkg::OUT_MIN : 24'(-$signed({1'b0, zq_p0}));
		end else begin
			fz_c = (zq_p0 > 25'd8388607) ? mtc_pkg::OUT_MAX : zq_p0[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
		end else begin
			vld_p1 <= xv_p0 && zv_p0;
		end
	end

	always_ff @(posedge clk) begin
		if (xovf_p0 || (dt > 26'(mtc_pkg::D_MAX))) begin
			d_p1 <= mtc_pkg::D_MAX;
		end else begin
			d_p1 <= 25'(dt);
		end
		fz_p1 <= fz_c;
		xtag_p1 <= xtag_p0;
		invz_p1 <= ztag_p0.inv_z;
	end

	// Post stage 2: d squared and d times xy1.
	logic [23:0]        ad;
	logic               vld_p2;
	logic [47:0]        dd_p2;
	logic signed [33:0] dx1_p2;
	logic signed [23:0] fz_p2;
	mtc_pkg::xy_tag_t   xtag_p2;
	logic               invz_p2;

	assign ad = 24'(d_p1[24] ? -d_p1 : d_p1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p2 <= 1'b0;
		end else begin
			vld_p2 <= vld_p1;
		end
	end

	always_ff @(posedge clk) begin
		dd_p2 <= 48'(ad) * 48'(ad);
		dx1_p2 <= 34'(d_p1) * $signed({26'd0, xy1});
		fz_p2 <= fz_p1;
		xtag_p2 <= xtag_p1;
		invz_p2 <= invz_p1;
	end

	// Post stage 3: xy2 times d squared.
	logic               vld_p3;
	logic signed [56:0] v_p3;
	logic signed [33:0] dx1_p3;
	logic signed [23:0] fz_p3;
	mtc_pkg::xy_tag_t   xtag_p3;
	logic               invz_p3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p3 <= 1'b0;
		end else begin
			vld_p3 <= vld_p2;
		end
	end

	always_ff @(posedge clk) begin
		v_p3 <= 57'(xy2) * $signed({9'd0, dd_p2});
		dx1_p3 <= dx1_p2;
		fz_p3 <= fz_p2;
		xtag_p3 <= xtag_p2;
		invz_p3 <= invz_p2;
	end

	// Post stage 4: gain term, truncated toward zero, plus the 2^22 bias.
	logic signed [56:0] vt;
	logic               vld_p4;
	logic signed [43:0] qq_p4;
	logic signed [23:0] fz_p4;
	mtc_pkg::xy_tag_t   xtag_p4;
	logic               invz_p4;

	assign vt = (v_p3 + (v_p3[56] ? 57'sd16383 : 57'sd0)) >>> 14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p4 <= 1'b0;
		end else begin
			vld_p4 <= vld_p3;
		end
	end

	always_ff @(posedge clk) begin
		qq_p4 <= 44'(vt) + 44'(dx1_p3) + 44'sd4194304;
		fz_p4 <= fz_p3;
		xtag_p4 <= xtag_p3;
		invz_p4 <= invz_p3;
	end

	// Post stage 5: partial products of the sensitivity term and the gain.
	logic signed [21:0] qh;
	logic signed [22:0] ql;
	logic               vld_p5;
	logic signed [43:0] hx_p5, hy_p5;
	logic signed [44:0] lx_p5, ly_p5;
	logic signed [23:0] fz_p5;
	logic               invx_p5, invy_p5, invz_p5;

	assign qh = qq_p4[43:22];
	assign ql = $signed({1'b0, qq_p4[21:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p5 <= 1'b0;
		end else begin
			vld_p5 <= vld_p4;
		end
	end

	always_ff @(posedge clk) begin
		hx_p5 <= 44'(xtag_p4.kx) * 44'(qh);
		hy_p5 <= 44'(xtag_p4.ky) * 44'(qh);
		lx_p5 <= 45'(xtag_p4.kx) * 45'(ql);
		ly_p5 <= 45'(xtag_p4.ky) * 45'(ql);
		fz_p5 <= fz_p4;
		invx_p5 <= xtag_p4.inv_x;
		invy_p5 <= xtag_p4.inv_y;
		invz_p5 <= invz_p4;
	end

	// Post stage 6: combine the partial products.
	logic               vld_p6;
	logic signed [63:0] px_p6, py_p6;
	logic signed [23:0] fz_p6;
	logic               invx_p6, invy_p6, invz_p6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p6 <= 1'b0;
		end else begin
			vld_p6 <= vld_p5;
		end
	end

	always_ff @(posedge clk) begin
		px_p6 <= (64'(hx_p5) <<< 22) + 64'(lx_p5);
		py_p6 <= (64'(hy_p5) <<< 22) + 64'(ly_p5);
		fz_p6 <= fz_p5;
		invx_p6 <= invx_p5;
		invy_p6 <= invy_p5;
		invz_p6 <= invz_p5;
	end

	// Output stage: scale down, add the offset trim, saturate and zero invalid axes.
	logic signed [36:0] tx, ty, sumx, sumy;
	logic signed [23:0] fx_c, fy_c;
	logic               done_q;
	mtc_pkg::out_item_t out_q;

	assign tx = 37'((px_p6 + (px_p6[63] ? 64'sd134217727 : 64'sd0)) >>> 27);
	assign ty = 37'((py_p6 + (py_p6[63] ? 64'sd134217727 : 64'sd0)) >>> 27);
	assign sumx = tx + (37'(x1) <<< 3);
	assign sumy = ty + (37'(y1) <<< 3);

	always_comb begin
		if (invx_p6) begin
			fx_c = '0;
		end else if (sumx > 37'(mtc_pkg::OUT_MAX)) begin
			fx_c = mtc_pkg::OUT_MAX;
		end else if (sumx < 37'(mtc_pkg::OUT_MIN)) begin
			fx_c = mtc_pkg::OUT_MIN;
		end else begin
			fx_c = 24'(sumx);
		end
		if (invy_p6) begin
			fy_c = '0;
		end else if (sumy > 37'(mtc_pkg::OUT_MAX)) begin
			fy_c = mtc_pkg::OUT_MAX;
		end else if (sumy < 37'(mtc_pkg::OUT_MIN)) begin
			fy_c = mtc_pkg::OUT_MIN;
		end else begin
			fy_c = 24'(sumy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_p6;
		end
	end

	always_ff @(posedge clk) begin
		out_q <= '{field_x: fx_c, field_y: fy_c, field_z: fz_p6,
			axis_invalid: {invz_p6, invy_p6, invx_p6}};
	end

	assign done = done_q;
	assign out_item = out_q;

	// A result appears only for a matching data-ready beat taken earlier.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && in_item.hall_low_byte[0], LAT))
		else $error("result without a matching data-ready beat");

	// An X or Z axis flagged invalid must read as zero.
	a_x_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_item.axis_invalid[0] |-> out_item.field_x == '0)
		else $error("invalid X axis not forced to zero");

	a_z_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_item.axis_invalid[2] |-> out_item.field_z == '0)
		else $error("invalid Z axis not forced to zero");

	// Both dividers run in lockstep.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		xv_p0 == zv_p0)
		else $error("divider valid bits out of step");

endmodule
